FILE: sv/rrvd_pkg.sv
// Shared types and constants for the round-robin voice level decay block.
`timescale 1ns / 1ps
`default_nettype none
package rrvd_pkg;

   localparam int SLOT_COUNT_DEFAULT = 8;

   localparam logic [15:0] HOLD_RESET    = 16'd40;
   localparam logic [6:0]  LEVEL_MAX     = 7'd127;
   localparam logic [6:0]  LEVEL_MIN     = 7'd1;
   localparam logic [4:0]  DECAY_DIVISOR = 5'd24;
   localparam logic [3:0]  COUNT_MAX     = 4'd15;

   // age / 24 == (age >> 3) / 3; /3 done as *171 >> 9, exact for the 9-bit range used
   localparam int          DECAY_PRE_SHIFT = 3;
   localparam logic [7:0]  DECAY_RECIP     = 8'd171;
   localparam int          DECAY_SHIFT     = 9;

   typedef enum logic [1:0] {
      OP_TRIGGER = 2'd0,
      OP_TICK    = 2'd1,
      OP_QUERY   = 2'd2,
      OP_SPARE   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic [7:0]  pad;
      logic [7:0]  label_id;
      logic [7:0]  velocity;
      logic [7:0]  query_index;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  active_count;
      logic        primary_valid;
      logic [7:0]  primary_pad;
      logic [7:0]  primary_label;
      logic [7:0]  queried_pad;
      logic [6:0]  queried_level;
      logic [7:0]  queried_label;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  pad;
      logic [6:0]  level;
      logic [31:0] stamp;
      logic [7:0]  label;
   } slot_type;

   // Broadcast to every voice; trigger and tick are already qualified by the pipeline advance
   typedef struct packed {
      logic        trigger;
      logic        tick;
      logic [31:0] now_ms;
      logic [7:0]  pad;
      logic [7:0]  label;
      logic [6:0]  level;
      logic [15:0] hold_ms;
   } voice_cmd_type;

endpackage
`default_nettype wire

FILE: sv/round_robin_voice_level_decay.sv
// Top level of the round-robin voice level decay block.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | req_payload_type
//   rsp     | out       | rsp_valid/ready    | rsp_payload_type
//   csr     | in        | csr_wr_en          | hold_ms (16 bit)
//
// One item per cycle sustained while rsp is not stalled; rsp_valid comes from the result register.
// An item sits in the input register, then all voices update in parallel and
// the report is captured in the result register in the same cycle.
// Reset (synchronous) empties both registers, idles all voices, hold_ms = 40.
// A stalled rsp holds the input register; req_ready falls only when both are full.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_voice_level_decay
   import rrvd_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [15:0]     csr_wr_data
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic [15:0]     hold_ff;
   logic [SLOT_W-1:0] next_slot_ff;
   logic [SLOT_W-1:0] next_slot_in;

   logic            advance;
   logic            do_trigger;
   voice_cmd_type   cmd;
   logic [6:0]      level_clamped;
   slot_type [SLOT_COUNT-1:0] slots_next;
   rsp_payload_type report;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign do_trigger = advance && (in_data_ff.opcode == OP_TRIGGER);

   always_comb begin
      priority if (in_data_ff.velocity < 8'(LEVEL_MIN)) begin
         level_clamped = LEVEL_MIN;
      end else if (in_data_ff.velocity > 8'(LEVEL_MAX)) begin
         level_clamped = LEVEL_MAX;
      end else begin
         level_clamped = in_data_ff.velocity[6:0];
      end
   end

   always_comb begin
      cmd.trigger = do_trigger;
      cmd.tick    = advance && (in_data_ff.opcode == OP_TICK);
      cmd.now_ms  = in_data_ff.now_ms;
      cmd.pad     = in_data_ff.pad;
      cmd.label   = in_data_ff.label_id;
      cmd.level   = level_clamped;
      cmd.hold_ms = hold_ff;
   end

   always_comb begin
      next_slot_in = next_slot_ff;
      if (do_trigger) begin
         next_slot_in = (next_slot_ff == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                  : next_slot_ff + SLOT_W'(1);
      end
   end

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_voice
      rrvd_voice u_voice (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .selected  (next_slot_ff == SLOT_W'(g)),
         .slot_next (slots_next[g])
      );
   end

   rrvd_report #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_report (
      .slots       (slots_next),
      .query_index (in_data_ff.query_index),
      .report      (report)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hold_ff      <= HOLD_RESET;
         next_slot_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            hold_ff <= csr_wr_data;
         end
         next_slot_ff <= next_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= report;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rrvd_voice.sv
// One voice slot: its state registers and its trigger and decay update.
`timescale 1ns / 1ps
`default_nettype none
module rrvd_voice
   import rrvd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire voice_cmd_type cmd,
   input  wire logic          selected,
   output slot_type           slot_next
);

   slot_type    slot_ff;
   slot_type    slot_in;
   logic [31:0] age;
   logic        due;
   logic        spent;
   logic [11:0] threshold;
   logic [8:0]  eighths;
   logic [16:0] product;
   logic [6:0]  quot;
   logic [6:0]  level_dec;

   assign age       = cmd.now_ms - slot_ff.stamp;
   assign due       = (slot_ff.pad != 8'd0) && (age >= {16'd0, cmd.hold_ms});
   assign threshold = 12'(slot_ff.level) * 12'(DECAY_DIVISOR);
   // age at or beyond level*24 takes the whole level; otherwise age fits in 12 bits
   assign spent     = age >= {20'd0, threshold};
   assign eighths   = age[11:DECAY_PRE_SHIFT];
   assign product   = 17'(eighths) * 17'(DECAY_RECIP);
   assign quot      = product[DECAY_SHIFT +: 7];
   assign level_dec = spent ? 7'd0 : (slot_ff.level - quot);

   always_comb begin
      slot_in = slot_ff;
      if (cmd.trigger && selected) begin
         slot_in.pad   = cmd.pad;
         slot_in.level = cmd.level;
         slot_in.stamp = cmd.now_ms;
         slot_in.label = cmd.label;
      end else if (cmd.tick && due) begin
         slot_in.level = level_dec;
         slot_in.stamp = cmd.now_ms;
         if (level_dec == 7'd0) begin
            slot_in.pad   = 8'd0;
            slot_in.label = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_next = slot_in;

endmodule
`default_nettype wire

FILE: sv/rrvd_report.sv
// Result builder: active count, first active voice and the queried slot.
`timescale 1ns / 1ps
`default_nettype none
module rrvd_report
   import rrvd_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  wire slot_type [SLOT_COUNT-1:0] slots,
   input  wire logic [7:0]                query_index,
   output rsp_payload_type                report
);

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int CW     = (CNT_W > 4) ? CNT_W : 4;

   logic [SLOT_COUNT-1:0] active;
   logic [CNT_W-1:0]      count;
   logic [CW-1:0]         count_ext;
   logic [SLOT_W-1:0]     q_idx;

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         active[i] = (slots[i].pad != 8'd0) && (slots[i].level != 7'd0);
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         count = count + CNT_W'(active[i]);
      end
   end

   assign count_ext = CW'(count);

   // out-of-range index reads slot 0
   assign q_idx = (query_index < 8'(SLOT_COUNT)) ? SLOT_W'(query_index) : '0;

   always_comb begin
      report = '0;
      report.active_count  = (count_ext > CW'(COUNT_MAX)) ? COUNT_MAX : 4'(count_ext);
      report.primary_valid = |active;
      // walk down so the lowest-numbered active voice wins
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (active[i]) begin
            report.primary_pad   = slots[i].pad;
            report.primary_label = slots[i].label;
         end
      end
      report.queried_pad   = slots[q_idx].pad;
      report.queried_level = slots[q_idx].level;
      report.queried_label = slots[q_idx].label;
   end

endmodule
`default_nettype wire

FILE: dv/tb_round_robin_voice_level_decay.sv
// Self-checking testbench for the round-robin voice level decay block.
`timescale 1ns / 1ps

module tb_round_robin_voice_level_decay;
   import rrvd_pkg::*;

   localparam int VOICES        = SLOT_COUNT_DEFAULT;
   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int MAX_GAP       = 16;
   localparam int LONG_HOLD     = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 322;
   localparam int PRINT_LIMIT   = 100;

   class voice_bank_checker;
      logic [7:0]      slot_pad   [VOICES];
      logic [6:0]      slot_level [VOICES];
      logic [31:0]     slot_stamp [VOICES];
      logic [7:0]      slot_label [VOICES];
      int              next_voice;
      logic [15:0]     hold_ms;
      rsp_payload_type expected_reports[$];
      int              errors;
      int              reports_checked;
      int              op_seen [4];
      int              voices_expired;

      function new();
         for (int i = 0; i < VOICES; i++) begin
            slot_pad[i]   = '0;
            slot_level[i] = '0;
            slot_stamp[i] = '0;
            slot_label[i] = '0;
         end
         for (int i = 0; i < 4; i++) op_seen[i] = 0;
         next_voice      = 0;
         hold_ms         = HOLD_RESET;
         errors          = 0;
         reports_checked = 0;
         voices_expired  = 0;
      endfunction

      // Applies one accepted request to the bank and queues the report it yields
      function void note_request(req_payload_type item);
         rsp_payload_type report;
         logic [31:0]     age;
         logic [31:0]     drop;
         logic [6:0]      level;
         int              shown;
         op_seen[item.opcode]++;
         case (opcode_type'(item.opcode))
            OP_TRIGGER: begin
               if (item.velocity < LEVEL_MIN) level = LEVEL_MIN;
               else if (item.velocity > LEVEL_MAX) level = LEVEL_MAX;
               else level = item.velocity[6:0];
               slot_pad[next_voice]   = item.pad;
               slot_level[next_voice] = level;
               slot_stamp[next_voice] = item.now_ms;
               slot_label[next_voice] = item.label_id;
               next_voice = (next_voice + 1) % VOICES;
            end
            OP_TICK: begin
               for (int i = 0; i < VOICES; i++) begin
                  age = item.now_ms - slot_stamp[i];
                  if (slot_pad[i] != 8'd0 && age >= 32'(hold_ms)) begin
                     drop = age / DECAY_DIVISOR;
                     if (drop > 32'(slot_level[i])) drop = 32'(slot_level[i]);
                     slot_level[i] = slot_level[i] - drop[6:0];
                     slot_stamp[i] = item.now_ms;
                     if (slot_level[i] == 7'd0) begin
                        slot_pad[i]   = '0;
                        slot_label[i] = '0;
                        voices_expired++;
                     end
                  end
               end
            end
            default: ;  // query only and the spare code leave the bank alone
         endcase
         report = '0;
         for (int i = 0; i < VOICES; i++) begin
            if (slot_pad[i] != 8'd0 && slot_level[i] != 7'd0) begin
               if (report.active_count < COUNT_MAX)
                  report.active_count = report.active_count + 4'd1;
               if (!report.primary_valid) begin
                  report.primary_valid = 1'b1;
                  report.primary_pad   = slot_pad[i];
                  report.primary_label = slot_label[i];
               end
            end
         end
         shown = (item.query_index < VOICES) ? int'(item.query_index) : 0;
         report.queried_pad   = slot_pad[shown];
         report.queried_level = slot_level[shown];
         report.queried_label = slot_label[shown];
         expected_reports.push_back(report);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= PRINT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: report with nothing outstanding, expected none, got %h",
                     $time, got);
            return;
         end
         want = expected_reports.pop_front();
         reports_checked++;
         compare_field("active_count",  want.active_count,  got.active_count);
         compare_field("primary_valid", want.primary_valid, got.primary_valid);
         compare_field("primary_pad",   want.primary_pad,   got.primary_pad);
         compare_field("primary_label", want.primary_label, got.primary_label);
         compare_field("queried_pad",   want.queried_pad,   got.queried_pad);
         compare_field("queried_level", want.queried_level, got.queried_level);
         compare_field("queried_label", want.queried_label, got.queried_label);
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_data    = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_wr_en   = 1'b0;
   logic [15:0]     csr_wr_data = '0;

   voice_bank_checker board;
   int          next_gap          = 0;
   bit          offering          = 1'b0;
   bit          sender_bursty     = 1'b0;
   bit          sink_bursty       = 1'b0;
   bit          long_hold_request = 1'b0;
   int          long_holds        = 0;
   logic [31:0] clock_ms          = '0;

   round_robin_voice_level_decay #(
      .SLOT_COUNT(VOICES)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // valid is only dropped when a gap follows, so back-to-back items keep it high
   task automatic send_request(input req_payload_type item);
      repeat (next_gap) @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      offering = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(item);
      next_gap = sender_bursty ? 0 : $urandom_range(0, MAX_GAP);
      if (next_gap > 0) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic stop_sending();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
   endtask

   task automatic wait_drained();
      stop_sending();
      while (board.expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_hold(input logic [15:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.hold_ms = value;
   endtask

   function automatic req_payload_type make_request(opcode_type op, logic [31:0] now,
                                                    logic [7:0] pad, logic [7:0] label,
                                                    logic [7:0] velocity,
                                                    logic [7:0] query);
      req_payload_type item;
      item.opcode      = op;
      item.now_ms      = now;
      item.pad         = pad;
      item.label_id    = label;
      item.velocity    = velocity;
      item.query_index = query;
      return item;
   endfunction

   // Mostly a running clock with triggers and ticks; some ticks land on or just beside the hold
   // boundary of a live voice, a few items are pure noise with an arbitrary time.
   function automatic req_payload_type random_request();
      req_payload_type item;
      int              pick;
      int              k;
      logic [31:0]     boundary;
      item.pad      = 8'($urandom_range(0, 255));
      item.label_id = 8'($urandom_range(0, 255));
      item.velocity = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0) item.query_index = 8'($urandom_range(0, 255));
      else item.query_index = 8'($urandom_range(0, VOICES - 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         item.opcode = OP_TRIGGER;
         clock_ms = clock_ms + $urandom_range(0, 30);
         if ($urandom_range(0, 9) == 0) item.pad = 8'd0;
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
               0:       item.velocity = 8'd0;
               1:       item.velocity = 8'd1;
               2:       item.velocity = 8'd127;
               3:       item.velocity = 8'd128;
               default: item.velocity = 8'd255;
            endcase
         end
      end else if (pick < 80) begin
         item.opcode = OP_TICK;
         k = $urandom_range(0, VOICES - 1);
         boundary = board.slot_stamp[k] + 32'(board.hold_ms) + 32'($urandom_range(0, 2))
                    - 32'd1;
         if ($urandom_range(0, 6) == 0 && board.slot_pad[k] != 8'd0
             && (boundary - clock_ms) < 32'h8000_0000) begin
            clock_ms = boundary;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75) clock_ms = clock_ms + $urandom_range(0, 80);
            else if (pick < 95) clock_ms = clock_ms + $urandom_range(0, 4000);
            else clock_ms = clock_ms + $urandom_range(0, 200000);
         end
      end else if (pick < 90) begin
         item.opcode = OP_QUERY;
      end else if (pick < 95) begin
         item.opcode = OP_SPARE;
      end else begin
         item.opcode = 2'($urandom_range(0, 3));
         item.now_ms = $urandom();
         return item;
      end
      item.now_ms = clock_ms;
      return item;
   endfunction

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            long_holds++;
            stall = LONG_HOLD;
         end else begin
            stall = sink_bursty ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result(rsp_data);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] hold_plan [PHASES];
      board = new();
      hold_plan = '{16'd40, 16'd0, 16'd65535, 16'd1, 16'd3000, 16'd0};
      hold_plan[PHASES - 1] = 16'($urandom_range(0, 65535));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, hold at its reset value
      send_request(make_request(OP_QUERY,   32'd0,   8'd0,   8'd0,   8'd0,   8'd0));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd255, 8'd255, 8'd255, 8'd0));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd1,   8'd1,   8'd0,   8'd1));
      // pad zero still fills the slot but never counts or decays
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd0,   8'd7,   8'd50,  8'd2));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd2,   8'd2,   8'd127, 8'd3));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd3,   8'd3,   8'd128, 8'd4));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd4,   8'd4,   8'd1,   8'd5));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd5,   8'd5,   8'd64,  8'd6));
      send_request(make_request(OP_TRIGGER, 32'd100, 8'd6,   8'd6,   8'd100, 8'd7));
      // pointer wraps back to slot 0
      send_request(make_request(OP_TRIGGER, 32'd110, 8'd7,   8'd8,   8'd90,  8'd0));
      send_request(make_request(OP_TICK,    32'd139, 8'd0,   8'd0,   8'd0,   8'd1));
      send_request(make_request(OP_TICK,    32'd140, 8'd0,   8'd0,   8'd0,   8'd1));
      send_request(make_request(OP_SPARE,   32'd140, 8'hFF,  8'hFF,  8'hFF,  8'd8));
      send_request(make_request(OP_QUERY,   32'd140, 8'd0,   8'd0,   8'd0,   8'd255));
      send_request(make_request(OP_TICK,    32'd3000, 8'd0,  8'd0,   8'd0,   8'd0));
      // time wraps between the trigger and the ticks
      send_request(make_request(OP_TRIGGER, 32'hFFFF_FFF0, 8'd9, 8'd9, 8'd127, 8'd1));
      send_request(make_request(OP_TICK,    32'h0000_0010, 8'd0, 8'd0, 8'd0,   8'd1));
      send_request(make_request(OP_TICK,    32'h0000_0100, 8'd0, 8'd0, 8'd0,   8'd1));
      send_request(make_request(OP_TICK,    32'h0020_0000, 8'd0, 8'd0, 8'd0,   8'd1));
      send_request(make_request(OP_QUERY,   32'h0020_0000, 8'd0, 8'd0, 8'd0,   8'd3));

      for (int phase = 0; phase < PHASES; phase++) begin
         write_hold(hold_plan[phase]);
         clock_ms = (phase == 2) ? 32'hFFFF_F000 : $urandom();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 64 == 0) begin
               sender_bursty = ($urandom_range(0, 3) == 0);
               sink_bursty   = ($urandom_range(0, 3) == 0);
            end
            // starve the output so both registers fill and req_ready drops
            if (n == 100) begin
               long_hold_request = 1'b1;
               sender_bursty     = 1'b1;
            end
            if (n == 200) wait_drained();
            send_request(random_request());
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run: %0d triggers, %0d ticks, %0d queries, %0d spare-code items; %0d voices decayed to idle.",
               board.op_seen[OP_TRIGGER], board.op_seen[OP_TICK], board.op_seen[OP_QUERY],
               board.op_seen[OP_SPARE], board.voices_expired);
      $display("Hold values %0d %0d %0d %0d %0d %0d; %0d long output stalls; %0d reports checked.",
               hold_plan[0], hold_plan[1], hold_plan[2], hold_plan[3], hold_plan[4],
               hold_plan[5], long_holds, board.reports_checked);
      if (board.errors == 0 && board.expected_reports.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
sv/rrvd_pkg.sv
sv/rrvd_voice.sv
sv/rrvd_report.sv
sv/round_robin_voice_level_decay.sv
dv/tb_round_robin_voice_level_decay.sv
